### design/assert_macros.svh
// Assertion macros shared by the RTL of the union-find claim checker.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property, checked at every rising edge outside reset.
`define RCUF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rcuf assertion failed");
// Expression that must never be true outside reset.
`define RCUF_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rcuf forbidden condition seen");
`else
`define RCUF_ASSERT(label, clk, rst, prop)
`define RCUF_NEVER(label, clk, rst, expr)
`endif
`endif

### design/rcuf_pkg.sv
// Package for the union-find claim checker: widths, limits, state codes
// and the layer table that picks the store nodes of each find. No dependencies.
package rcuf_pkg;

  localparam int MAX_ANIMALS = 16384;
  localparam int STORE_DEPTH = 3 * MAX_ANIMALS;
  localparam int NODE_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(MAX_ANIMALS);
  localparam int CNT_W       = 15;
  localparam int TALLY_W     = 20;
  localparam int PAIR_W      = 3;

  localparam logic [TALLY_W-1:0] TALLY_MAX       = {TALLY_W{1'b1}};
  localparam logic [CNT_W-1:0]   COUNT_RESET     = CNT_W'(MAX_ANIMALS);
  localparam logic [CNT_W-1:0]   COUNT_LIMIT     = CNT_W'(MAX_ANIMALS);
  localparam logic [NODE_W-1:0]  CLEAR_LAST      = NODE_W'(STORE_DEPTH - 1);
  localparam logic [PAIR_W-1:0]  PAIR_FIRST_JOIN = 3'd2;
  localparam logic [PAIR_W-1:0]  PAIR_LAST       = 3'd4;

  localparam logic [1:0] LAYER_0 = 2'd0;
  localparam logic [1:0] LAYER_1 = 2'd1;
  localparam logic [1:0] LAYER_2 = 2'd2;

  localparam logic OP_SAME = 1'b0;
  localparam logic OP_EATS = 1'b1;

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_FIND_RD  = 6'b000100,
    S_FIND_CHK = 6'b001000,
    S_COMP_WR  = 6'b010000,
    S_STEP     = 6'b100000
  } state_t;

  // Layer of the node searched by one find. Pairs 0 and 1 are compared,
  // pairs 2 to 4 are joined; half 0 uses x, half 1 uses y.
  function automatic logic [1:0] layer_of(input logic op, input logic [PAIR_W-1:0] pair,
                                          input logic half);
    logic [1:0] layer;
    layer = LAYER_0;
    if (op == OP_SAME) begin
      case ({pair, half})
        {3'd0, 1'b0}: layer = LAYER_1;
        {3'd1, 1'b1}: layer = LAYER_1;
        {3'd3, 1'b0}: layer = LAYER_1;
        {3'd3, 1'b1}: layer = LAYER_1;
        {3'd4, 1'b0}: layer = LAYER_2;
        {3'd4, 1'b1}: layer = LAYER_2;
        default:      layer = LAYER_0;
      endcase
    end else begin
      case ({pair, half})
        {3'd1, 1'b1}: layer = LAYER_1;
        {3'd2, 1'b1}: layer = LAYER_2;
        {3'd3, 1'b0}: layer = LAYER_1;
        {3'd4, 1'b0}: layer = LAYER_2;
        {3'd4, 1'b1}: layer = LAYER_1;
        default:      layer = LAYER_0;
      endcase
    end
    return layer;
  endfunction

endpackage

### design/relation_consistency_union_find_unit.sv
// Top level of the union-find claim checker: sequencer and parent store.
// Depends on rcuf_pkg and on assert_macros.svh.
`include "assert_macros.svh"

// Checks claims about a cyclic three-class relation with an extended
// union-find over a 49152-entry parent store (three layers of MAX_ANIMALS
// nodes). A claim is taken when start is high and busy is low; its verdict
// and the running false tally appear for exactly one cycle with done high,
// and the receiver cannot stall them. After reset the block sweeps the store
// to identity, one entry per cycle, so busy stays high through the whole
// sweep before the first claim; configuration writes are taken at any time
// (cfg_ready is always high) but should be made while busy is low. A claim
// naming an individual out of range is answered the cycle after it is taken.
// A valid claim runs up to ten finds on the single-read, single-write store;
// a find reads the links one by one on the walk up from its start node to
// its root, then writes the root into each node below it on that walk in
// the path compression pass, plus issue and bookkeeping states. A claim
// found false stops after its failing comparison. The speed is set by the
// one read per cycle of the store and the serial walk of the parent chains.
module relation_consistency_union_find_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [rcuf_pkg::CNT_W-1:0]    animal_x,
  input  logic [rcuf_pkg::CNT_W-1:0]    animal_y,
  output logic                          done,
  output logic                          is_false,
  output logic [rcuf_pkg::TALLY_W-1:0]  false_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcuf_pkg::CNT_W-1:0]    cfg_data
);
  import rcuf_pkg::*;

  state_t               state;
  logic [CNT_W-1:0]     animal_count;
  logic [CNT_W-1:0]     n_eff;
  logic [NODE_W-1:0]    clr_idx;

  // Latched claim.
  logic                 op_r;
  logic [IDX_W-1:0]     xi;
  logic [IDX_W-1:0]     yi;
  logic [NODE_W-1:0]    off_n;
  logic [NODE_W-1:0]    off_2n;

  // Sequencer registers.
  logic [PAIR_W-1:0]    pair;
  logic                 half;
  logic [NODE_W-1:0]    cur;
  logic [NODE_W-1:0]    start_node;
  logic [NODE_W-1:0]    root;
  logic [NODE_W-1:0]    ra;

  // Parent store.
  logic [NODE_W-1:0]    mem [STORE_DEPTH];
  logic [NODE_W-1:0]    rdata;
  logic                 mem_we;
  logic [NODE_W-1:0]    mem_waddr;
  logic [NODE_W-1:0]    mem_wdata;
  logic [NODE_W-1:0]    mem_raddr;

  logic                 accept;
  logic                 range_bad;
  logic [CNT_W-1:0]     x_dec;
  logic [CNT_W-1:0]     y_dec;
  logic [NODE_W-1:0]    node;
  logic [NODE_W-1:0]    node_base;
  logic [NODE_W-1:0]    node_off;
  logic [1:0]           layer;
  logic [TALLY_W-1:0]   tally_inc;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  // A count above the store's capacity acts as the capacity.
  assign n_eff = (animal_count > COUNT_LIMIT) ? COUNT_LIMIT : animal_count;

  assign range_bad = (animal_x == '0) || (animal_y == '0) ||
                     (animal_x > n_eff) || (animal_y > n_eff);
  assign x_dec = animal_x - CNT_W'(1);
  assign y_dec = animal_y - CNT_W'(1);

  assign tally_inc = (false_count == TALLY_MAX) ? false_count
                                                : false_count + TALLY_W'(1);

  // Store node searched by the current find: individual plus layer offset.
  assign layer     = layer_of(op_r, pair, half);
  assign node_base = half ? NODE_W'(yi) : NODE_W'(xi);
  always_comb begin
    case (layer)
      LAYER_1: node_off = off_n;
      LAYER_2: node_off = off_2n;
      default: node_off = '0;
    endcase
  end
  assign node = node_base + node_off;

  // Store access for each sequencer state. The read address follows the
  // registered read data directly, so no state is spent between links.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = root;
    mem_raddr = cur;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = clr_idx;
      end
      S_FIND_RD: begin
        mem_raddr = node;
      end
      S_FIND_CHK: begin
        mem_raddr = (rdata == cur) ? start_node : rdata;
      end
      S_COMP_WR: begin
        // Point the node on the walk at the root and fetch the next link.
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = root;
        mem_raddr = rdata;
      end
      S_STEP: begin
        // Join: the root of the first node now points at the root of the second.
        mem_we    = half && (pair >= PAIR_FIRST_JOIN);
        mem_waddr = ra;
        mem_wdata = root;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      animal_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      animal_count <= cfg_data;
    end
  end

  // Claim sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      done        <= 1'b0;
      false_count <= '0;
      pair        <= '0;
      half        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + NODE_W'(1);
          if (clr_idx == CLEAR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r   <= op;
            xi     <= x_dec[IDX_W-1:0];
            yi     <= y_dec[IDX_W-1:0];
            off_n  <= NODE_W'(n_eff);
            off_2n <= {n_eff, 1'b0};
            pair   <= '0;
            half   <= 1'b0;
            if (range_bad) begin
              done        <= 1'b1;
              is_false    <= 1'b1;
              false_count <= tally_inc;
            end else begin
              state <= S_FIND_RD;
            end
          end
        end
        S_FIND_RD: begin
          cur        <= node;
          start_node <= node;
          state      <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (rdata == cur) begin
            root <= cur;
            if (start_node == cur) begin
              state <= S_STEP;
            end else begin
              cur   <= start_node;
              state <= S_COMP_WR;
            end
          end else begin
            cur <= rdata;
          end
        end
        S_COMP_WR: begin
          if (rdata == root) begin
            state <= S_STEP;
          end else begin
            cur <= rdata;
          end
        end
        S_STEP: begin
          if (!half) begin
            ra    <= root;
            half  <= 1'b1;
            state <= S_FIND_RD;
          end else begin
            half <= 1'b0;
            if (pair < PAIR_FIRST_JOIN && ra == root) begin
              done        <= 1'b1;
              is_false    <= 1'b1;
              false_count <= tally_inc;
              state       <= S_IDLE;
            end else if (pair == PAIR_LAST) begin
              done     <= 1'b1;
              is_false <= 1'b0;
              state    <= S_IDLE;
            end else begin
              pair  <= pair + PAIR_W'(1);
              state <= S_FIND_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only given once the sequencer is back at rest.
  `RCUF_ASSERT(a_done_idle, clk, rst, done |-> !busy)
  // A taken claim either starts its finds or is answered at once.
  `RCUF_ASSERT(a_accept_moves, clk, rst, accept |=> (busy || done))
  // The walk up a chain never writes the store.
  `RCUF_NEVER(a_no_write_in_walk, clk, rst,
              (state == S_FIND_RD || state == S_FIND_CHK) && mem_we)
  // Compression never reads the entry it is rewriting in the same cycle.
  `RCUF_NEVER(a_comp_no_overlap, clk, rst,
              state == S_COMP_WR && rdata != root && mem_raddr == mem_waddr)
  // The false tally never goes down.
  `RCUF_ASSERT(a_tally_monotone, clk, rst, 1'b1 |=> false_count >= $past(false_count))

endmodule

### tb/sv/relation_consistency_union_find_unit_tb.sv
// Self-checking testbench for relation_consistency_union_find_unit: directed and random claims,
// predicted by a local union-find copy of the parent store and tally, checked beat by beat.
// Depends on rcuf_pkg and the RTL top level only.
`timescale 1ns / 100ps

module relation_consistency_union_find_unit_tb;

  import rcuf_pkg::*;

  // Watchdog limit in cycles with no beat on any port. The store clear
  // after reset alone keeps busy high while it sweeps all STORE_DEPTH entries.
  localparam int STALL_LIMIT = 200000;
  // Cycles allowed after the last expected result before the verdict.
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic               op;
    logic [CNT_W-1:0]   x;
    logic [CNT_W-1:0]   y;
  } claim_t;

  typedef struct {
    logic               bad;
    logic [TALLY_W-1:0] tally;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 op = OP_SAME;
  logic [CNT_W-1:0]     animal_x = '0;
  logic [CNT_W-1:0]     animal_y = '0;
  logic                 cfg_valid = 1'b0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 busy;
  logic                 done;
  logic                 is_false;
  logic [TALLY_W-1:0]   false_count;
  logic                 cfg_ready;

  // Claims waiting to be driven, and verdicts predicted for claims already taken.
  claim_t   claim_q[$];
  verdict_t verdict_q[$];

  // Local copy of the block's state: the parent store, the false tally and
  // the animal count register.
  int unsigned        link_store [STORE_DEPTH];
  logic [TALLY_W-1:0] false_tally;
  logic [CNT_W-1:0]   animal_limit;

  int in_flight     = 0;
  int idle_pct      = 0;
  int mismatches    = 0;
  int claims_taken  = 0;
  int false_seen    = 0;
  int settings_used = 1;
  int quiet_cycles  = 0;

  relation_consistency_union_find_unit uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .animal_x    (animal_x),
    .animal_y    (animal_y),
    .done        (done),
    .is_false    (is_false),
    .false_count (false_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Root of a node, with path compression. Compression never changes which
  // root a node reaches, so it only keeps the walks short.
  function automatic int unsigned find_root(input int unsigned node);
    int unsigned r;
    int unsigned walk;
    int unsigned nxt;
    r = node;
    while (link_store[r] != r) r = link_store[r];
    walk = node;
    while (walk != r) begin
      nxt = link_store[walk];
      link_store[walk] = r;
      walk = nxt;
    end
    return r;
  endfunction

  // Hang the root of a under the root of b.
  function automatic void link_pair(input int unsigned a, input int unsigned b);
    int unsigned ra;
    int unsigned rb;
    ra = find_root(a);
    rb = find_root(b);
    link_store[ra] = rb;
  endfunction

  // Verdict on one claim under the current count; accepted claims merge
  // the three layer pairs and false ones bump the saturating tally.
  function automatic logic judge_claim(input logic kind, input logic [CNT_W-1:0] ax,
                                       input logic [CNT_W-1:0] ay);
    int unsigned n;
    int unsigned xi;
    int unsigned yi;
    logic bad;
    n = (animal_limit > COUNT_LIMIT) ? MAX_ANIMALS : animal_limit;
    if (ax == 0 || ay == 0 || ax > n || ay > n) begin
      bad = 1'b1;
    end else begin
      xi = ax - 1;
      yi = ay - 1;
      if (kind == OP_SAME) begin
        // Same class contradicts either individual preceding the other.
        bad = (find_root(xi + n) == find_root(yi)) || (find_root(yi + n) == find_root(xi));
        if (!bad) begin
          link_pair(xi, yi);
          link_pair(xi + n, yi + n);
          link_pair(xi + 2 * n, yi + 2 * n);
        end
      end else begin
        // Precedence contradicts the same class or y preceding x.
        bad = (find_root(xi) == find_root(yi)) || (find_root(xi) == find_root(yi + n));
        if (!bad) begin
          link_pair(xi, yi + 2 * n);
          link_pair(xi + n, yi);
          link_pair(xi + 2 * n, yi + n);
        end
      end
    end
    if (bad && false_tally != TALLY_MAX) false_tally = false_tally + 1'b1;
    return bad;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_claim(input logic kind, input int unsigned ax, input int unsigned ay);
    claim_t c;
    c.op = kind;
    c.x  = CNT_W'(ax);
    c.y  = CNT_W'(ay);
    claim_q.push_back(c);
    in_flight++;
  endtask

  // Returns at a rising edge once every claim has been answered and the
  // block has dropped busy.
  task automatic wait_drained();
    do @(posedge clk); while (in_flight != 0 || busy);
  endtask

  // One beat on the configuration channel while the block is idle.
  task automatic write_animal_count(input int unsigned value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    animal_limit = CNT_W'(value);
    settings_used++;
  endtask

  // Random claims under one count setting. Most claims are valid pairs drawn
  // from a narrow window of individuals, so that classes actually merge and
  // contradictions arise; the rest are zero, out-of-range or raw values.
  task automatic run_random_claims(input int unsigned count, input int pct, input int total);
    int unsigned n_eff;
    int unsigned win;
    int unsigned base;
    int unsigned roll;
    int unsigned ax;
    int unsigned ay;
    write_animal_count(count);
    idle_pct = pct;
    n_eff = (count > MAX_ANIMALS) ? MAX_ANIMALS : count;
    win   = (n_eff < 48) ? n_eff : 48;
    base  = 0;
    for (int i = 0; i < total; i++) begin
      if (i % 64 == 0) base = $urandom_range(0, n_eff - win);
      roll = $urandom_range(0, 99);
      ax = base + $urandom_range(1, win);
      ay = base + $urandom_range(1, win);
      if (roll >= 85 && roll < 90) begin
        if (roll[0]) ax = 0;
        else ay = 0;
      end else if (roll >= 90 && roll < 95) begin
        if (roll[0]) ax = n_eff + 1;
        else ay = n_eff + 1;
      end else if (roll >= 95) begin
        ax = $urandom_range(0, 32767);
        ay = $urandom_range(0, 32767);
      end
      push_claim(logic'($urandom_range(0, 1)), ax, ay);
    end
  endtask

  // Driver: presents the next pending claim when the line is free or the
  // current claim is taken at this edge, with random gaps between claims.
  always @(posedge clk) begin : drive_claims
    claim_t   nxt;
    verdict_t want;
    logic     taken;
    taken = !rst && start && !busy;
    if (taken) begin
      want.bad   = judge_claim(op, animal_x, animal_y);
      want.tally = false_tally;
      verdict_q.push_back(want);
      claims_taken++;
    end
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (claim_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = claim_q.pop_front();
        start    <= 1'b1;
        op       <= nxt.op;
        animal_x <= nxt.x;
        animal_y <= nxt.y;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result beat is compared with the oldest prediction. The
  // watchdog runs here too and counts edges with no beat on any port.
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && done) begin
      if (is_false === 1'b1) false_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result beat with no claim outstanding: is_false %0b count %0d",
                                  is_false, false_count));
      end else begin
        want = verdict_q.pop_front();
        in_flight--;
        if (is_false !== want.bad)
          report_mismatch($sformatf("is_false %0b, predicted %0b", is_false, want.bad));
        if (false_count !== want.tally)
          report_mismatch($sformatf("false_count %0d, predicted %0d", false_count, want.tally));
      end
    end
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: %0d cycles without a beat, %0d results outstanding",
                 $realtime, quiet_cycles, in_flight);
        $display("relation_consistency_union_find_unit_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < STORE_DEPTH; i++) link_store[i] = i;
    false_tally  = '0;
    animal_limit = COUNT_RESET;
    idle_pct     = 14;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Let the block enter its store clear before waiting on busy.
    repeat (2) @(posedge clk);
    wait_drained();

    // Directed claims at the reset count: a consistent precedence cycle,
    // its contradictions, self precedence, the highest individual, and the
    // zero and above-count individuals.
    push_claim(OP_SAME, 1, 1);
    push_claim(OP_EATS, 5, 5);
    push_claim(OP_EATS, 1, 2);
    push_claim(OP_EATS, 2, 3);
    push_claim(OP_EATS, 3, 1);
    push_claim(OP_SAME, 1, 3);
    push_claim(OP_EATS, 1, 3);
    push_claim(OP_SAME, 16384, 16384);
    push_claim(OP_EATS, 16384, 1);
    push_claim(OP_SAME, 0, 4);
    push_claim(OP_EATS, 4, 0);
    push_claim(OP_SAME, 16385, 1);
    push_claim(OP_EATS, 1, 32767);
    push_claim(OP_SAME, 32767, 32767);

    // A count of zero rejects everything.
    write_animal_count(0);
    push_claim(OP_SAME, 1, 1);
    push_claim(OP_EATS, 1, 2);

    // A count above the store size behaves as the largest count.
    write_animal_count(32767);
    push_claim(OP_SAME, 16384, 2);
    push_claim(OP_EATS, 16385, 2);

    // A count of one reuses entries merged under the old layer offsets.
    write_animal_count(1);
    push_claim(OP_SAME, 1, 1);
    push_claim(OP_EATS, 1, 1);
    push_claim(OP_SAME, 1, 2);
    push_claim(OP_EATS, 2, 1);

    // Random phases: light sender gaps, heavy gaps, then back to back.
    run_random_claims(8, 14, 350);
    run_random_claims($urandom_range(40, 300), 52, 350);
    run_random_claims(16384, 0, 350);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", verdict_q.size()));

    $display("Checked %0d claims under %0d count settings, %0d of them judged false.",
             claims_taken, settings_used, false_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("relation_consistency_union_find_unit_tb OK");
    end else begin
      $display("relation_consistency_union_find_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
